FILE: rtl/ckvq_pkg.sv
// ----------------------------------------------------------------------------
// ckvq_pkg
// Shared types and codes of the coalescing key/value queue.
// ----------------------------------------------------------------------------
package ckvq_pkg;

	localparam int KEY_W = 16;
	localparam int VAL_W = 16;
	localparam int STATUS_W = 3;
	localparam int OCC_W = 5;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_POP
	} ctrl_state_t;

endpackage

FILE: rtl/ckvq_mem.sv
// ----------------------------------------------------------------------------
// ckvq_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ckvq_mem #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  ckvq_pkg::entry_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output ckvq_pkg::entry_t rdata
);

	ckvq_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/ckvq_ctrl.sv
// ----------------------------------------------------------------------------
// ckvq_ctrl
// Sequencer: ring pointers, serial key search through the entry store,
// pop of the head entry and the result register.
// ----------------------------------------------------------------------------
module ckvq_ctrl #(
	parameter int DEPTH = 16,
	parameter int AW = 4,
	parameter int CW = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           kind,
	input  logic [ckvq_pkg::KEY_W-1:0]     key,
	input  logic [ckvq_pkg::VAL_W-1:0]     value,
	output logic                           done,
	output logic [ckvq_pkg::STATUS_W-1:0]  status,
	output logic [ckvq_pkg::KEY_W-1:0]     out_key,
	output logic [ckvq_pkg::VAL_W-1:0]     out_value,
	output logic [ckvq_pkg::OCC_W-1:0]     occupancy,
	output logic                           mem_we,
	output logic [AW-1:0]                  mem_waddr,
	output ckvq_pkg::entry_t               mem_wdata,
	output logic                           mem_re,
	output logic [AW-1:0]                  mem_raddr,
	input  ckvq_pkg::entry_t               mem_rdata
);

	ckvq_pkg::ctrl_state_t state_q, state_nxt;

	logic [AW-1:0] head_q, tail_q, scan_addr_q, rd_addr_s1;
	logic [CW-1:0] count_q, issue_cnt_q, fin_count;
	logic [ckvq_pkg::KEY_W-1:0] key_q;
	logic [ckvq_pkg::VAL_W-1:0] value_q;
	logic rd_vld_s1;
	logic hit, miss, full, accept;
	logic do_append, do_pop, issue_first, issue_next, fin;
	logic [ckvq_pkg::STATUS_W-1:0] fin_status;
	ckvq_pkg::entry_t fin_entry;

	logic done_q;
	logic [ckvq_pkg::STATUS_W-1:0] status_q;
	logic [ckvq_pkg::KEY_W-1:0] out_key_q;
	logic [ckvq_pkg::VAL_W-1:0] out_value_q;
	logic [ckvq_pkg::OCC_W-1:0] occupancy_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		next_ptr = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign accept = start && (state_q == ckvq_pkg::S_IDLE);
	assign full   = (count_q == CW'(DEPTH));
	assign hit    = (state_q == ckvq_pkg::S_SEARCH) && rd_vld_s1 && (mem_rdata.key == key_q);
	assign miss   = (state_q == ckvq_pkg::S_SEARCH) && rd_vld_s1 && !hit
		&& (issue_cnt_q == count_q);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ckvq_pkg::S_IDLE: begin
				if (start && (count_q != '0)) begin
					state_nxt = (kind == ckvq_pkg::KIND_POP) ? ckvq_pkg::S_POP
						: ckvq_pkg::S_SEARCH;
				end
			end
			ckvq_pkg::S_SEARCH: begin
				if (hit || miss) begin
					state_nxt = ckvq_pkg::S_IDLE;
				end
			end
			ckvq_pkg::S_POP: begin
				state_nxt = ckvq_pkg::S_IDLE;
			end
			default: begin
				state_nxt = ckvq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = tail_q;
		mem_wdata   = '{key: key_q, value: value_q};
		mem_re      = 1'b0;
		mem_raddr   = head_q;
		do_append   = 1'b0;
		do_pop      = 1'b0;
		issue_first = 1'b0;
		issue_next  = 1'b0;
		fin         = 1'b0;
		fin_status  = ckvq_pkg::ST_APPENDED;
		fin_entry   = '0;
		case (state_q)
			ckvq_pkg::S_IDLE: begin
				if (start) begin
					if (count_q == '0) begin
						fin = 1'b1;
						if (kind == ckvq_pkg::KIND_POP) begin
							fin_status = ckvq_pkg::ST_EMPTY;
						end else begin
							mem_we     = 1'b1;
							mem_wdata  = '{key: key, value: value};
							do_append  = 1'b1;
							fin_status = ckvq_pkg::ST_APPENDED;
						end
					end else begin
						mem_re      = 1'b1;
						issue_first = (kind == ckvq_pkg::KIND_PUSH);
					end
				end
			end
			ckvq_pkg::S_SEARCH: begin
				if (issue_cnt_q != count_q) begin
					mem_re     = 1'b1;
					mem_raddr  = scan_addr_q;
					issue_next = 1'b1;
				end
				if (hit) begin
					mem_we     = 1'b1;
					mem_waddr  = rd_addr_s1;
					fin        = 1'b1;
					fin_status = ckvq_pkg::ST_UPDATED;
				end else if (miss) begin
					fin = 1'b1;
					if (full) begin
						fin_status = ckvq_pkg::ST_DROPPED;
					end else begin
						mem_we     = 1'b1;
						do_append  = 1'b1;
						fin_status = ckvq_pkg::ST_APPENDED;
					end
				end
			end
			ckvq_pkg::S_POP: begin
				fin        = 1'b1;
				do_pop     = 1'b1;
				fin_status = ckvq_pkg::ST_POPPED;
				fin_entry  = mem_rdata;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_comb begin
		fin_count = count_q;
		if (do_append) begin
			fin_count = count_q + CW'(1);
		end else if (do_pop) begin
			fin_count = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ckvq_pkg::S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			count_q   <= fin_count;
			rd_vld_s1 <= mem_re;
			done_q    <= fin;
			if (do_append) begin
				tail_q <= next_ptr(tail_q);
			end
			if (do_pop) begin
				head_q <= next_ptr(head_q);
			end
			if (issue_first) begin
				issue_cnt_q <= CW'(1);
			end else if (issue_next) begin
				issue_cnt_q <= issue_cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= mem_raddr;
		if (accept) begin
			key_q   <= key;
			value_q <= value;
		end
		if (issue_first) begin
			scan_addr_q <= next_ptr(head_q);
		end else if (issue_next) begin
			scan_addr_q <= next_ptr(scan_addr_q);
		end
		if (fin) begin
			status_q    <= fin_status;
			out_key_q   <= fin_entry.key;
			out_value_q <= fin_entry.value;
			occupancy_q <= ckvq_pkg::OCC_W'(fin_count);
		end
	end

	assign busy      = (state_q != ckvq_pkg::S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_value = out_value_q;
	assign occupancy = occupancy_q;

endmodule

FILE: rtl/coalescing_key_value_queue.sv
// ----------------------------------------------------------------------------
// coalescing_key_value_queue
// Ordered key/value queue that holds each key once; a push of a queued key
// overwrites its value in place.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result appears on
// the result ports in the cycle after the item's work ends, for one cycle, with
// done high; the receiver cannot stall it. The entries sit in a ring in one
// memory with a single read port, so a push searches them one per cycle and
// stops early on a match; a push into an empty queue writes without a search.
// A pop reads the head entry and then finishes, and a pop on an empty queue
// reports empty without a read.
module coalescing_key_value_queue #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [ckvq_pkg::KEY_W-1:0]    key,
	input  logic [ckvq_pkg::VAL_W-1:0]    value,
	output logic                          done,
	output logic [ckvq_pkg::STATUS_W-1:0] status,
	output logic [ckvq_pkg::KEY_W-1:0]    out_key,
	output logic [ckvq_pkg::VAL_W-1:0]    out_value,
	output logic [ckvq_pkg::OCC_W-1:0]    occupancy
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	ckvq_pkg::entry_t mem_wdata, mem_rdata;

	ckvq_ctrl #(
		.DEPTH(DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key(key),
		.value(value),
		.done(done),
		.status(status),
		.out_key(out_key),
		.out_value(out_value),
		.occupancy(occupancy),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ckvq_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

FILE: rtl/ckvq_checker.sv
// ----------------------------------------------------------------------------
// ckvq_checker
// Port-level checks of the coalescing key/value queue, bound to the top level.
// ----------------------------------------------------------------------------
module ckvq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          kind,
	input logic                          done,
	input logic [ckvq_pkg::STATUS_W-1:0] status,
	input logic [ckvq_pkg::KEY_W-1:0]    out_key,
	input logic [ckvq_pkg::VAL_W-1:0]    out_value,
	input logic [ckvq_pkg::OCC_W-1:0]    occupancy
);

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither in progress nor finished");

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ckvq_pkg::ST_POPPED) |-> (out_key == '0 && out_value == '0))
		else $error("non-pop result carries an entry");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ckvq_pkg::ST_EMPTY) |-> (occupancy == '0))
		else $error("empty pop with entries held");

	a_append_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ckvq_pkg::ST_APPENDED) |-> (occupancy != '0))
		else $error("append leaves queue empty");

	a_pop_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == ckvq_pkg::KIND_POP) |=> !(done && status == ckvq_pkg::ST_UPDATED))
		else $error("pop reported as update");

endmodule

bind coalescing_key_value_queue ckvq_checker u_ckvq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.kind(kind),
	.done(done),
	.status(status),
	.out_key(out_key),
	.out_value(out_value),
	.occupancy(occupancy)
);

FILE: dv/tb_coalescing_key_value_queue.sv
// ----------------------------------------------------------------------------
// tb_coalescing_key_value_queue
// Self-checking testbench of the coalescing key/value queue. A directed table
// covers the empty, full, update-in-place and extreme-value cases. Random
// push/pop traffic follows, drawn largely from a small pool of keys so that
// updates and drops at full occur often. Directed results are checked against
// the table, random ones against a queue model kept in step with each item.
// ----------------------------------------------------------------------------
module tb_coalescing_key_value_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import ckvq_pkg::*;

	localparam int DEPTH          = 16;
	localparam int RANDOM_ITEMS   = 725;
	localparam int CALM_ITEMS     = 100;
	localparam int KEY_POOL       = 24;
	localparam int TAIL_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    out_key;
		logic [VAL_W-1:0]    out_value;
		logic [OCC_W-1:0]    occupancy;
	} result_t;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic             typed;
		result_t          res;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                kind = KIND_PUSH;
	logic [KEY_W-1:0]    key = '0;
	logic [VAL_W-1:0]    value = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    out_key;
	logic [VAL_W-1:0]    out_value;
	logic [OCC_W-1:0]    occupancy;

	logic                item_typed = 1'b0;
	result_t             item_typed_res = '0;

	logic [KEY_W-1:0]    held_keys[DEPTH];
	logic [VAL_W-1:0]    held_values[DEPTH];
	int                  held_count = 0;
	result_t             pending_results[$];
	int                  mismatch_count = 0;
	int                  quiet_cycles = 0;

	stim_row_t directed_rows[25] = '{
		'{KIND_POP,  16'h0000, 16'h0000, 1'b1, '{ST_EMPTY,    16'h0000, 16'h0000, 5'd0}},
		'{KIND_PUSH, 16'h0000, 16'h0000, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd1}},
		'{KIND_PUSH, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd2}},
		'{KIND_PUSH, 16'h0000, 16'hFFFF, 1'b1, '{ST_UPDATED,  16'h0000, 16'h0000, 5'd2}},
		'{KIND_POP,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_POPPED,   16'h0000, 16'hFFFF, 5'd1}},
		'{KIND_POP,  16'h0000, 16'h0000, 1'b1, '{ST_POPPED,   16'hFFFF, 16'hFFFF, 5'd0}},
		'{KIND_POP,  16'hFFFF, 16'hFFFF, 1'b1, '{ST_EMPTY,    16'h0000, 16'h0000, 5'd0}},
		'{KIND_PUSH, 16'h0001, 16'hFFFE, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd1}},
		'{KIND_PUSH, 16'h0002, 16'hFFFD, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd2}},
		'{KIND_PUSH, 16'h0004, 16'hFFFB, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd3}},
		'{KIND_PUSH, 16'h0008, 16'hFFF7, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd4}},
		'{KIND_PUSH, 16'h0010, 16'hFFEF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd5}},
		'{KIND_PUSH, 16'h0020, 16'hFFDF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd6}},
		'{KIND_PUSH, 16'h0040, 16'hFFBF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd7}},
		'{KIND_PUSH, 16'h0080, 16'hFF7F, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd8}},
		'{KIND_PUSH, 16'h0100, 16'hFEFF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd9}},
		'{KIND_PUSH, 16'h0200, 16'hFDFF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd10}},
		'{KIND_PUSH, 16'h0400, 16'hFBFF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd11}},
		'{KIND_PUSH, 16'h0800, 16'hF7FF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd12}},
		'{KIND_PUSH, 16'h1000, 16'hEFFF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd13}},
		'{KIND_PUSH, 16'h2000, 16'hDFFF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd14}},
		'{KIND_PUSH, 16'h4000, 16'hBFFF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd15}},
		'{KIND_PUSH, 16'h8000, 16'h7FFF, 1'b1, '{ST_APPENDED, 16'h0000, 16'h0000, 5'd16}},
		'{KIND_PUSH, 16'h1234, 16'hBEEF, 1'b1, '{ST_DROPPED,  16'h0000, 16'h0000, 5'd16}},
		'{KIND_PUSH, 16'h8000, 16'h0000, 1'b1, '{ST_UPDATED,  16'h0000, 16'h0000, 5'd16}}
	};

	coalescing_key_value_queue #(
		.DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.key      (key),
		.value    (value),
		.done     (done),
		.status   (status),
		.out_key  (out_key),
		.out_value(out_value),
		.occupancy(occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t apply_queue_op(input logic op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		result_t r;
		bit hit;
		r = '0;
		hit = 1'b0;
		if (op == KIND_PUSH) begin
			for (int i = 0; i < held_count; i++) begin
				if (!hit && held_keys[i] == k) begin
					held_values[i] = v;
					hit = 1'b1;
				end
			end
			if (hit) begin
				r.status = ST_UPDATED;
			end else if (held_count >= DEPTH) begin
				r.status = ST_DROPPED;
			end else begin
				held_keys[held_count] = k;
				held_values[held_count] = v;
				held_count++;
				r.status = ST_APPENDED;
			end
		end else if (held_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			r.status = ST_POPPED;
			r.out_key = held_keys[0];
			r.out_value = held_values[0];
			for (int i = 0; i + 1 < held_count; i++) begin
				held_keys[i] = held_keys[i+1];
				held_values[i] = held_values[i+1];
			end
			held_count--;
		end
		r.occupancy = held_count[OCC_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		result_t got;
		if (arst_n) begin
			got = '{status, out_key, out_value, occupancy};
			if (done) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("Unexpected result: status %0d key %h value %h occupancy %0d",
							got.status, got.out_key, got.out_value, got.occupancy);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.out_key !== want.out_key ||
							got.out_value !== want.out_value ||
							got.occupancy !== want.occupancy) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display({"Mismatch: expected status %0d key %h value %h ",
								"occupancy %0d, got status %0d key %h value %h occupancy %0d"},
								want.status, want.out_key, want.out_value, want.occupancy,
								got.status, got.out_key, got.out_value, got.occupancy);
					end
				end
			end
			if (start && !busy) begin
				want = apply_queue_op(kind, key, value);
				if (item_typed)
					want = item_typed_res;
				pending_results.push_back(want);
			end
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no item or result for %0d cycles", WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic send_item(input logic op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, input logic typed, input result_t res);
		kind <= op;
		key <= k;
		value <= v;
		item_typed <= typed;
		item_typed_res <= res;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_for_results();
		if (pending_results.size() != 0) begin
			start <= 1'b0;
			while (pending_results.size() != 0) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		logic             op;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] pool[KEY_POOL];
		int               push_pct;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			send_item(directed_rows[r].kind, directed_rows[r].key, directed_rows[r].value,
				directed_rows[r].typed, directed_rows[r].res);
			if ($urandom_range(3) == 0)
				pause_sender($urandom_range(1, 4));
		end
		wait_for_results();

		// Most keys come from a small pool so that updates and drops at full are common.
		foreach (pool[p]) pool[p] = KEY_W'($urandom);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				wait_for_results();
			case ((n / 60) % 4)
				0: push_pct = 85;
				1: push_pct = 50;
				2: push_pct = 15;
				default: push_pct = 65;
			endcase
			op = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
			k = ($urandom_range(9) < 7) ? pool[$urandom_range(KEY_POOL - 1)] : KEY_W'($urandom);
			send_item(op, k, VAL_W'($urandom), 1'b0, '0);
			if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(3) == 0)
				pause_sender($urandom_range(1, 4));
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ckvq_pkg.sv
rtl/ckvq_mem.sv
rtl/ckvq_ctrl.sv
rtl/coalescing_key_value_queue.sv
rtl/ckvq_checker.sv
dv/tb_coalescing_key_value_queue.sv
